### hdl/assert_macros.svh
// Assertion macros used by the allocator datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/ffa_pkg.sv
// Types and constants of the first-fit pool allocator.
`default_nettype none

package ffa_pkg;

    localparam int START_W = 26;
    localparam int SIZE_W  = 27;
    localparam int FAIL_W  = 32;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 200;

    localparam logic [SIZE_W-1:0] HDR_BYTES  = 27'd64;
    localparam logic [SIZE_W-1:0] MIN_POOL   = 27'd128;
    localparam logic [SIZE_W-1:0] POOL_LIMIT = 27'd67108864;
    localparam logic [FAIL_W-1:0] FAIL_MAX   = 32'hFFFF_FFFF;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_POOL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_START = 3'd4;
    localparam logic [STAT_W-1:0] ST_DOUBLE    = 3'd5;

    typedef struct packed {
        logic                free;
        logic [SIZE_W-1:0]   size;
        logic [START_W-1:0]  start;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK, S_SCAN, S_APLAN, S_ASHIFT, S_AWNEW, S_AWCUR,
        S_FRDN, S_FRDP, S_FRDW, S_FMERGE, S_FSHIFT, S_SVINIT, S_SURV, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_INIT, OP_IDLE, OP_CHECK, OP_SCAN, OP_APLAN, OP_ASHIFT, OP_AWNEW, OP_AWCUR,
        OP_FRDN, OP_FRDP, OP_FRDW, OP_FMERGE, OP_FSHIFT, OP_SVINIT, OP_SURV, OP_DONE
    } op_t;

    typedef struct packed {
        logic kind_free;
        logic pre_fail;
        logic hit;
        logic hit_free;
        logic scan_end;
        logic split;
        logic pipe_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hdl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/ffa_ctrl.sv
// Sequencer of the allocator: one request at a time through scan, update and survey.
`default_nettype none

module ffa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          in_fire,
    input  wire ffa_pkg::sts_t sts,
    output logic               in_ready,
    output ffa_pkg::op_t       op
);

    ffa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::S_INIT:   state_next = ffa_pkg::S_IDLE;
            ffa_pkg::S_IDLE:   if (in_fire) state_next = ffa_pkg::S_CHECK;
            ffa_pkg::S_CHECK:
            begin
                state_next = sts.pre_fail ? ffa_pkg::S_SVINIT : ffa_pkg::S_SCAN;
            end
            ffa_pkg::S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (!sts.kind_free)
                        state_next = ffa_pkg::S_APLAN;
                    else if (sts.hit_free)
                        state_next = ffa_pkg::S_SVINIT;
                    else
                        state_next = ffa_pkg::S_FRDN;
                end
                else if (sts.scan_end)
                begin
                    state_next = ffa_pkg::S_SVINIT;
                end
            end
            ffa_pkg::S_APLAN:
            begin
                state_next = sts.split ? ffa_pkg::S_ASHIFT : ffa_pkg::S_AWCUR;
            end
            ffa_pkg::S_ASHIFT: if (sts.pipe_done) state_next = ffa_pkg::S_AWNEW;
            ffa_pkg::S_AWNEW:  state_next = ffa_pkg::S_AWCUR;
            ffa_pkg::S_AWCUR:  state_next = ffa_pkg::S_SVINIT;
            ffa_pkg::S_FRDN:   state_next = ffa_pkg::S_FRDP;
            ffa_pkg::S_FRDP:   state_next = ffa_pkg::S_FRDW;
            ffa_pkg::S_FRDW:   state_next = ffa_pkg::S_FMERGE;
            ffa_pkg::S_FMERGE: state_next = ffa_pkg::S_FSHIFT;
            ffa_pkg::S_FSHIFT: if (sts.pipe_done) state_next = ffa_pkg::S_SVINIT;
            ffa_pkg::S_SVINIT: state_next = ffa_pkg::S_SURV;
            ffa_pkg::S_SURV:   if (sts.pipe_done) state_next = ffa_pkg::S_DONE;
            ffa_pkg::S_DONE:   if (sts.out_free) state_next = ffa_pkg::S_IDLE;
            default:           state_next = ffa_pkg::S_INIT;
        endcase
        if (cfg_we)
        begin
            state_next = ffa_pkg::S_INIT;
        end
    end

    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            ffa_pkg::S_INIT:   op = ffa_pkg::OP_INIT;
            ffa_pkg::S_IDLE:
            begin
                op       = ffa_pkg::OP_IDLE;
                in_ready = !cfg_we;
            end
            ffa_pkg::S_CHECK:  op = ffa_pkg::OP_CHECK;
            ffa_pkg::S_SCAN:   op = ffa_pkg::OP_SCAN;
            ffa_pkg::S_APLAN:  op = ffa_pkg::OP_APLAN;
            ffa_pkg::S_ASHIFT: op = ffa_pkg::OP_ASHIFT;
            ffa_pkg::S_AWNEW:  op = ffa_pkg::OP_AWNEW;
            ffa_pkg::S_AWCUR:  op = ffa_pkg::OP_AWCUR;
            ffa_pkg::S_FRDN:   op = ffa_pkg::OP_FRDN;
            ffa_pkg::S_FRDP:   op = ffa_pkg::OP_FRDP;
            ffa_pkg::S_FRDW:   op = ffa_pkg::OP_FRDW;
            ffa_pkg::S_FMERGE: op = ffa_pkg::OP_FMERGE;
            ffa_pkg::S_FSHIFT: op = ffa_pkg::OP_FSHIFT;
            ffa_pkg::S_SVINIT: op = ffa_pkg::OP_SVINIT;
            ffa_pkg::S_SURV:   op = ffa_pkg::OP_SURV;
            ffa_pkg::S_DONE:   op = ffa_pkg::OP_DONE;
            default:           op = ffa_pkg::OP_INIT;
        endcase
    end

endmodule

`default_nettype wire

### hdl/ffa_dp.sv
// Allocator datapath: block table RAM, counters, scan and shift pointers, result register.
`default_nettype none
`include "assert_macros.svh"

module ffa_dp #(
    parameter int MAX_BLOCKS = 256
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ffa_pkg::op_t              op,
    input  wire logic                      cfg_we,
    input  wire logic [ffa_pkg::SIZE_W-1:0] cfg_wdata,
    input  wire logic                      in_fire,
    input  wire logic                      in_kind,
    input  wire logic [ffa_pkg::IN_W-1:0]  in_data,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic      [ffa_pkg::OUT_W-1:0] out_data,
    output ffa_pkg::sts_t                  sts
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = AW + 1;
    localparam int SW = ffa_pkg::SIZE_W;
    localparam int PW = ffa_pkg::START_W;

    // control state
    logic [SW-1:0]             plen_reg, plen_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [SW-1:0]             used_reg, used_next;
    logic [SW-1:0]             peak_reg, peak_next;
    logic [ffa_pkg::FAIL_W-1:0] fail_reg, fail_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      out_valid_reg, out_valid_next;

    // payload state
    logic                      kind_reg, kind_next;
    logic [SW:0]               want_reg, want_next;
    logic [PW-1:0]             off_reg, off_next;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic [AW-1:0]             rd_idx_reg, rd_idx_next;
    logic [AW-1:0]             idx_reg, idx_next;
    ffa_pkg::ent_t             ent_reg, ent_next;
    ffa_pkg::ent_t             nxt_reg, nxt_next;
    ffa_pkg::ent_t             prv_reg, prv_next;
    logic                      split_reg, split_next;
    logic [1:0]                k_reg, k_next;
    logic [ffa_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [PW-1:0]             grant_reg, grant_next;
    logic [SW-1:0]             given_reg, given_next;
    logic [SW-1:0]             tot_reg, tot_next;
    logic [SW-1:0]             big_reg, big_next;
    logic [ffa_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // RAM port
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    ffa_pkg::ent_t             ram_wdata, ram_rdata;
    logic [ffa_pkg::ENT_W-1:0] ram_rbits;

    ffa_ram #(.WIDTH(ffa_pkg::ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );
    assign ram_rdata = ffa_pkg::ent_t'(ram_rbits);

    // request decode
    logic [SW-1:0] req_w;
    logic [SW:0]   want_w;
    logic [PW-1:0] hdr_w;
    logic          fit_w, match_w, issue_lt, bad_free;
    logic [SW+1:0] split_need;
    logic          nvalid, nf, pf;
    logic [SW-1:0] msize, cur_size;
    logic [AW-1:0] t_w;
    logic [1:0]    k_w;

    assign req_w  = in_data[SW-1:0];
    assign want_w = (({1'b0, (req_w == '0) ? SW'(1) : req_w}) + (SW+1)'(63))
                    & ~((SW+1)'(63));
    assign hdr_w  = off_reg - PW'(ffa_pkg::HDR_BYTES);
    assign fit_w  = ({1'b0, ram_rdata.size} >= want_reg);
    assign match_w = rd_vld_reg && (kind_reg ? (ram_rdata.start == hdr_w)
                                             : (ram_rdata.free && fit_w));
    assign issue_lt = (ptr_reg < cnt_reg);
    assign bad_free = (cnt_reg == '0) || (off_reg < PW'(ffa_pkg::HDR_BYTES))
                      || ({1'b0, off_reg} >= plen_reg);
    assign split_need = {1'b0, want_reg} + (SW+2)'(ffa_pkg::MIN_POOL);

    // merge planning on a free
    assign nvalid = ({1'b0, idx_reg} + CW'(1)) < cnt_reg;
    assign nf     = nvalid && nxt_reg.free;
    assign pf     = (idx_reg != '0) && prv_reg.free;
    assign msize  = ent_reg.size + (nf ? (ffa_pkg::HDR_BYTES + nxt_reg.size) : '0);
    assign t_w    = pf ? (idx_reg - AW'(1)) : idx_reg;
    assign k_w    = {1'b0, nf} + {1'b0, pf};
    assign cur_size = split_reg ? want_reg[SW-1:0] : ent_reg.size;

    always_comb
    begin
        plen_next      = plen_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        fail_next      = fail_reg;
        rd_vld_next    = 1'b0;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        want_next      = want_reg;
        off_next       = off_reg;
        ptr_next       = ptr_reg;
        rd_idx_next    = rd_idx_reg;
        idx_next       = idx_reg;
        ent_next       = ent_reg;
        nxt_next       = nxt_reg;
        prv_next       = prv_reg;
        split_next     = split_reg;
        k_next         = k_reg;
        stat_next      = stat_reg;
        grant_next     = grant_reg;
        given_next     = given_reg;
        tot_next       = tot_reg;
        big_next       = big_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = ptr_reg[AW-1:0];

        sts           = '0;
        sts.kind_free = kind_reg;
        sts.out_free  = !out_valid_reg || out_ready;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (op)
            ffa_pkg::OP_INIT:
            begin
                cnt_next = (plen_reg >= ffa_pkg::MIN_POOL) ? CW'(1) : '0;
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{free: 1'b1, size: plen_reg - ffa_pkg::HDR_BYTES, start: '0};
            end
            ffa_pkg::OP_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next = in_kind;
                    want_next = want_w;
                    off_next  = in_data[SW +: PW];
                end
            end
            ffa_pkg::OP_CHECK:
            begin
                stat_next  = ffa_pkg::ST_OK;
                grant_next = '0;
                given_next = '0;
                ptr_next   = '0;
                if (!kind_reg && cnt_reg == '0)
                begin
                    sts.pre_fail = 1'b1;
                    stat_next    = ffa_pkg::ST_NO_POOL;
                end
                else if (kind_reg && bad_free)
                begin
                    sts.pre_fail = 1'b1;
                    stat_next    = ffa_pkg::ST_OUTSIDE;
                end
            end
            ffa_pkg::OP_SCAN:
            begin
                if (issue_lt)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                if (match_w)
                begin
                    sts.hit      = 1'b1;
                    sts.hit_free = ram_rdata.free;
                    idx_next     = rd_idx_reg;
                    ent_next     = ram_rdata;
                    if (kind_reg && ram_rdata.free)
                        stat_next = ffa_pkg::ST_DOUBLE;
                end
                else if (!issue_lt && !rd_vld_reg)
                begin
                    sts.scan_end = 1'b1;
                    if (kind_reg)
                    begin
                        stat_next = ffa_pkg::ST_NOT_START;
                    end
                    else
                    begin
                        stat_next = ffa_pkg::ST_EXHAUSTED;
                        if (fail_reg != ffa_pkg::FAIL_MAX)
                            fail_next = fail_reg + 32'd1;
                    end
                end
            end
            ffa_pkg::OP_APLAN:
            begin
                sts.split  = ({2'b0, ent_reg.size} >= split_need)
                             && (cnt_reg < CW'(MAX_BLOCKS));
                split_next = sts.split;
                ptr_next   = cnt_reg - CW'(1);
            end
            ffa_pkg::OP_ASHIFT:
            begin
                // move entries idx+1 .. cnt-1 one place up, highest first
                if (ptr_reg > {1'b0, idx_reg})
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg - CW'(1);
                end
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                sts.pipe_done = !(ptr_reg > {1'b0, idx_reg}) && !rd_vld_reg;
            end
            ffa_pkg::OP_AWNEW:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                ram_wdata = '{free: 1'b1,
                              size: ent_reg.size - want_reg[SW-1:0] - ffa_pkg::HDR_BYTES,
                              start: ent_reg.start + PW'(ffa_pkg::HDR_BYTES) + want_reg[PW-1:0]};
                cnt_next  = cnt_reg + CW'(1);
            end
            ffa_pkg::OP_AWCUR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = '{free: 1'b0, size: cur_size, start: ent_reg.start};
                used_next  = used_reg + ffa_pkg::HDR_BYTES + cur_size;
                if (used_next > peak_reg)
                    peak_next = used_next;
                grant_next = ent_reg.start + PW'(ffa_pkg::HDR_BYTES);
                given_next = cur_size;
            end
            ffa_pkg::OP_FRDN:
            begin
                ram_raddr = idx_reg + AW'(1);
            end
            ffa_pkg::OP_FRDP:
            begin
                ram_raddr = idx_reg - AW'(1);
                nxt_next  = ram_rdata;
            end
            ffa_pkg::OP_FRDW:
            begin
                prv_next = ram_rdata;
            end
            ffa_pkg::OP_FMERGE:
            begin
                ram_we    = 1'b1;
                ram_waddr = t_w;
                if (pf)
                    ram_wdata = '{free: 1'b1,
                                  size: prv_reg.size + ffa_pkg::HDR_BYTES + msize,
                                  start: prv_reg.start};
                else
                    ram_wdata = '{free: 1'b1, size: msize, start: ent_reg.start};
                used_next = used_reg - ffa_pkg::HDR_BYTES - ent_reg.size;
                k_next    = k_w;
                ptr_next  = {1'b0, t_w} + CW'(1) + CW'(k_w);
            end
            ffa_pkg::OP_FSHIFT:
            begin
                // close the gap left by merged entries, lowest first
                if (issue_lt)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - AW'(k_reg);
                    ram_wdata = ram_rdata;
                end
                sts.pipe_done = !issue_lt && !rd_vld_reg;
                if (sts.pipe_done)
                    cnt_next = cnt_reg - CW'(k_reg);
            end
            ffa_pkg::OP_SVINIT:
            begin
                ptr_next = '0;
                tot_next = '0;
                big_next = '0;
            end
            ffa_pkg::OP_SURV:
            begin
                if (issue_lt)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                if (rd_vld_reg && ram_rdata.free)
                begin
                    tot_next = tot_reg + ram_rdata.size;
                    if (ram_rdata.size > big_reg)
                        big_next = ram_rdata.size;
                end
                sts.pipe_done = !issue_lt && !rd_vld_reg;
            end
            ffa_pkg::OP_DONE:
            begin
                if (sts.out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, fail_reg, big_reg, tot_reg, peak_reg,
                                      used_reg, given_reg, grant_reg, stat_reg};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        if (cfg_we)
        begin
            plen_next = (cfg_wdata > ffa_pkg::POOL_LIMIT) ? ffa_pkg::POOL_LIMIT : cfg_wdata;
            used_next = '0;
            peak_next = '0;
            fail_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= ffa_pkg::POOL_LIMIT;
            cnt_reg       <= '0;
            used_reg      <= '0;
            peak_reg      <= '0;
            fail_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            fail_reg      <= fail_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        want_reg     <= want_next;
        off_reg      <= off_next;
        ptr_reg      <= ptr_next;
        rd_idx_reg   <= rd_idx_next;
        idx_reg      <= idx_next;
        ent_reg      <= ent_next;
        nxt_reg      <= nxt_next;
        prv_reg      <= prv_next;
        split_reg    <= split_next;
        k_reg        <= k_next;
        stat_reg     <= stat_next;
        grant_reg    <= grant_next;
        given_reg    <= given_next;
        tot_reg      <= tot_next;
        big_reg      <= big_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(MAX_BLOCKS), "block count past table depth")
    `ASSERT_ALWAYS(a_used_le_peak, used_reg <= peak_reg, "used bytes above peak")
    `ASSERT_IMPLY(a_load_in_done, $rose(out_valid_reg), $past(op == ffa_pkg::OP_DONE),
        "result loaded outside done step")
    `ASSERT_IMPLY(a_merge_count, op == ffa_pkg::OP_FMERGE, k_w != 2'd3,
        "merge removes more than two entries")

endmodule

`default_nettype wire

### hdl/first_fit_dma_pool_allocator.sv
// Top level of the first-fit pool allocator with coalescing.
// Allocate takes the first free block that fits, splitting it when the tail can hold a block;
//   free merges with free neighbours and closes the gap; misses and rejects only survey.
// Requests: one at a time; the next is accepted only after the result has loaded.
// Reset: the init state writes entry 0 (pool mapped at 67108864 bytes), then idle.
`default_nettype none

module first_fit_dma_pool_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config: pool_length_bytes
    input  wire logic         cfg_we,
    input  wire logic [26:0]  cfg_wdata,
    // request beats
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [55:0]  s_axis_tdata,   // request_bytes[26:0], release_offset[52:27]
    input  wire logic         s_axis_tuser,   // kind: 0 allocate, 1 free
    // result beats
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [199:0] m_axis_tdata    // status[2:0], grant_offset[28:3],
                                              // granted_bytes[55:29], used_bytes[82:56],
                                              // peak_bytes[109:83], free_total[136:110],
                                              // largest_free[163:137], fail_count[195:164]
);

    ffa_pkg::op_t  op;
    ffa_pkg::sts_t sts;
    logic          in_ready;
    logic          in_fire;

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    // sequencer: holds the request flow, the datapath does the table walks
    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_fire  (in_fire),
        .sts      (sts),
        .in_ready (in_ready),
        .op       (op)
    );

    // table RAM, pool counters and the output register
    ffa_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_kind   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .sts       (sts)
    );

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the first-fit pool allocator.
`default_nettype none

module tb;

    localparam int      MAX_ENTRIES = 256;
    localparam int      START_BITS  = ffa_pkg::START_W;
    localparam int      SIZE_BITS   = ffa_pkg::SIZE_W;
    localparam int      FAIL_BITS   = ffa_pkg::FAIL_W;
    localparam int      STAT_BITS   = ffa_pkg::STAT_W;
    localparam longint  HDR_LEN     = longint'(ffa_pkg::HDR_BYTES);
    localparam longint  FAIL_TOP    = longint'(ffa_pkg::FAIL_MAX);
    localparam bit      KIND_ALLOC  = 1'b0;
    localparam bit      KIND_FREE   = 1'b1;
    localparam int      HOLD_CYCLES = 3000;      // long receiver stall
    localparam int      STALL_LIMIT = 20000;     // cycles with no beat before giving up
    localparam longint  POOL_MAX    = 64'd67108864;

    // how a free picks its offset
    typedef enum int {REL_LIVE, REL_FREE_BLK, REL_INNER, REL_GONE, REL_NOISE} rel_pick_t;

    typedef struct packed {
        logic [FAIL_BITS-1:0]  fails;
        logic [SIZE_BITS-1:0]  largest;
        logic [SIZE_BITS-1:0]  ftotal;
        logic [SIZE_BITS-1:0]  peak;
        logic [SIZE_BITS-1:0]  used;
        logic [SIZE_BITS-1:0]  granted;
        logic [START_BITS-1:0] grant;
        logic [STAT_BITS-1:0]  status;
    } pool_result_t;

    // Mirror of the block table plus a queue of expected results.
    class pool_scoreboard;
        longint              pool_len;
        bit [START_BITS-1:0] blk_start  [MAX_ENTRIES];
        bit [SIZE_BITS-1:0]  blk_size   [MAX_ENTRIES];
        bit                  blk_vacant [MAX_ENTRIES];
        int                  blk_count;
        longint              used_sum, used_max, fail_cnt;
        longint              gone_offs[$];
        pool_result_t        pending[$];
        int                  errors;
        int                  status_seen[8];
        int                  results_seen;

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void set_pool_length(longint len);
            pool_len = (len > POOL_MAX) ? POOL_MAX : len;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                blk_start[i]  = '0;
                blk_size[i]   = '0;
                blk_vacant[i] = 1'b0;
            end
            used_sum  = 0;
            used_max  = 0;
            fail_cnt  = 0;
            blk_count = 0;
            gone_offs.delete();
            if (pool_len >= HDR_LEN + 64)
            begin
                blk_size[0]   = SIZE_BITS'(pool_len - HDR_LEN);
                blk_vacant[0] = 1'b1;
                blk_count     = 1;
            end
        endfunction

        function void insert_at(int pos, longint st, longint sz);
            for (int j = blk_count; j > pos; j--)
            begin
                blk_start[j]  = blk_start[j-1];
                blk_size[j]   = blk_size[j-1];
                blk_vacant[j] = blk_vacant[j-1];
            end
            blk_start[pos]  = START_BITS'(st);
            blk_size[pos]   = SIZE_BITS'(sz);
            blk_vacant[pos] = 1'b1;
            blk_count++;
        endfunction

        function void remove_at(int pos);
            gone_offs.push_back(longint'(blk_start[pos]) + HDR_LEN);
            if (gone_offs.size() > 32)
                void'(gone_offs.pop_front());
            for (int j = pos; j + 1 < blk_count; j++)
            begin
                blk_start[j]  = blk_start[j+1];
                blk_size[j]   = blk_size[j+1];
                blk_vacant[j] = blk_vacant[j+1];
            end
            blk_count--;
        endfunction

        // payload offset for a free request of the given flavor
        function longint pick_offset(rel_pick_t how);
            int cand[$];
            int k;
            if (how == REL_GONE && gone_offs.size() > 0)
                return gone_offs[$urandom_range(gone_offs.size() - 1)];
            for (int i = 0; i < blk_count; i++)
                if (blk_vacant[i] == (how == REL_FREE_BLK))
                    cand.push_back(i);
            if (how == REL_NOISE || how == REL_GONE || cand.size() == 0)
                return longint'($urandom_range(67108863));
            k = cand[$urandom_range(cand.size() - 1)];
            if (how == REL_INNER)
                return longint'(blk_start[k]) + HDR_LEN + 64 * longint'($urandom_range(1, 4))
                       - longint'($urandom_range(1));
            return longint'(blk_start[k]) + HDR_LEN;
        endfunction

        function void note_request(bit kind, longint req, longint off);
            pool_result_t e;
            longint want, hdr, tot, big;
            int i;
            e = '0;
            if (kind == KIND_ALLOC)
            begin
                if (blk_count == 0)
                    e.status = ffa_pkg::ST_NO_POOL;
                else
                begin
                    want = ((req == 0 ? 1 : req) + 63) & ~longint'(63);
                    for (i = 0; i < blk_count; i++)
                        if (blk_vacant[i] && longint'(blk_size[i]) >= want)
                            break;
                    if (i >= blk_count)
                    begin
                        e.status = ffa_pkg::ST_EXHAUSTED;
                        if (fail_cnt < FAIL_TOP)
                            fail_cnt++;
                    end
                    else
                    begin
                        // split only if the tail holds a header and one granule
                        if (longint'(blk_size[i]) >= want + HDR_LEN + 64
                            && blk_count < MAX_ENTRIES)
                        begin
                            insert_at(i + 1, longint'(blk_start[i]) + HDR_LEN + want,
                                      longint'(blk_size[i]) - want - HDR_LEN);
                            blk_size[i] = SIZE_BITS'(want);
                        end
                        blk_vacant[i] = 1'b0;
                        used_sum += HDR_LEN + longint'(blk_size[i]);
                        if (used_sum > used_max)
                            used_max = used_sum;
                        e.status  = ffa_pkg::ST_OK;
                        e.grant   = START_BITS'(longint'(blk_start[i]) + HDR_LEN);
                        e.granted = blk_size[i];
                    end
                end
            end
            else if (blk_count == 0 || off < HDR_LEN || off >= pool_len)
                e.status = ffa_pkg::ST_OUTSIDE;
            else
            begin
                hdr = off - HDR_LEN;
                for (i = 0; i < blk_count; i++)
                    if (longint'(blk_start[i]) == hdr)
                        break;
                if (i >= blk_count)
                    e.status = ffa_pkg::ST_NOT_START;
                else if (blk_vacant[i])
                    e.status = ffa_pkg::ST_DOUBLE;
                else
                begin
                    e.status = ffa_pkg::ST_OK;
                    used_sum -= HDR_LEN + longint'(blk_size[i]);
                    blk_vacant[i] = 1'b1;
                    if (i + 1 < blk_count && blk_vacant[i+1])
                    begin
                        blk_size[i] = SIZE_BITS'(longint'(blk_size[i]) + HDR_LEN
                                                 + longint'(blk_size[i+1]));
                        remove_at(i + 1);
                    end
                    if (i > 0 && blk_vacant[i-1])
                    begin
                        blk_size[i-1] = SIZE_BITS'(longint'(blk_size[i-1]) + HDR_LEN
                                                   + longint'(blk_size[i]));
                        remove_at(i);
                    end
                end
            end
            tot = 0;
            big = 0;
            for (i = 0; i < blk_count; i++)
                if (blk_vacant[i])
                begin
                    tot += longint'(blk_size[i]);
                    if (longint'(blk_size[i]) > big)
                        big = longint'(blk_size[i]);
                end
            e.used    = SIZE_BITS'(used_sum);
            e.peak    = SIZE_BITS'(used_max);
            e.ftotal  = SIZE_BITS'(tot);
            e.largest = SIZE_BITS'(big);
            e.fails   = FAIL_BITS'(fail_cnt);
            pending.push_back(e);
        endfunction

        task check_result(pool_result_t got);
            pool_result_t e;
            results_seen++;
            status_seen[got.status]++;
            if (pending.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report_mismatch($sformatf("status got %0d exp %0d", got.status, e.status));
            if (got.grant !== e.grant)
                report_mismatch($sformatf("grant_offset got %0d exp %0d", got.grant, e.grant));
            if (got.granted !== e.granted)
                report_mismatch($sformatf("granted_bytes got %0d exp %0d",
                                          got.granted, e.granted));
            if (got.used !== e.used)
                report_mismatch($sformatf("used_bytes got %0d exp %0d", got.used, e.used));
            if (got.peak !== e.peak)
                report_mismatch($sformatf("peak_bytes got %0d exp %0d", got.peak, e.peak));
            if (got.ftotal !== e.ftotal)
                report_mismatch($sformatf("free_total got %0d exp %0d", got.ftotal, e.ftotal));
            if (got.largest !== e.largest)
                report_mismatch($sformatf("largest_free got %0d exp %0d",
                                          got.largest, e.largest));
            if (got.fails !== e.fails)
                report_mismatch($sformatf("fail_count got %0d exp %0d", got.fails, e.fails));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [26:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;     // request_bytes[26:0], release_offset[52:27]
    logic         s_axis_tuser;     // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;     // status, grant, granted, used, peak, free, largest, fails

    pool_scoreboard pool_sb;
    bit             quiet;          // no idling on either side while set
    bit             hold_req;       // asks the receiver for one long stall
    int             stall_cycles;
    int             cfg_writes;

    first_fit_dma_pool_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Monitor: beats and config writes update the mirror at the rising edge,
    // in the same order the block sees them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                pool_sb.set_pool_length(longint'(cfg_wdata));
            if (s_axis_tvalid && s_axis_tready)
                pool_sb.note_request(s_axis_tuser, longint'(s_axis_tdata[26:0]),
                                     longint'(s_axis_tdata[52:27]));
            if (m_axis_tvalid && m_axis_tready)
                pool_sb.check_result(m_axis_tdata[195:0]);
        end
    end

    // Watchdog on cycles where no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random ready, with one long hold-off on request so the
    // block keeps a result parked and stops taking requests.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_axis_tready = quiet || ($urandom_range(99) >= 38);
        end
    end

    // One request beat; returns at the falling edge after acceptance with
    // tvalid still high so back-to-back beats never drop it.
    task automatic send_request(bit kind, longint req, longint off);
        if (!quiet)
            while ($urandom_range(99) < 38)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {3'b000, off[25:0], req[26:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_free(rel_pick_t how);
        send_request(KIND_FREE, longint'($urandom_range(67108864)), pool_sb.pick_offset(how));
    endtask

    // Drain, then write the pool length while the block is idle.
    task automatic write_pool_length(longint len);
        s_axis_tvalid = 1'b0;
        while (pool_sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = len[26:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random(int n, int alloc_pct);
        int r;
        longint sz;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if ($urandom_range(99) < alloc_pct)
            begin
                // mostly small requests so the table fills; a few huge ones
                if (r < 70)
                    sz = longint'($urandom_range(1024));
                else if (r < 90)
                    sz = longint'($urandom_range(65536));
                else if (r < 96)
                    sz = longint'($urandom_range(int'(pool_sb.pool_len)));
                else
                    sz = longint'($urandom_range(67108864));
                send_request(KIND_ALLOC, sz, longint'($urandom_range(67108863)));
            end
            else if (r < 70)
                send_free(REL_LIVE);
            else if (r < 80)
                send_free(REL_FREE_BLK);
            else if (r < 88)
                send_free(REL_INNER);
            else if (r < 94)
                send_free(REL_GONE);
            else
                send_free(REL_NOISE);
        end
    endtask

    initial
    begin
        pool_sb = new();
        pool_sb.set_pool_length(POOL_MAX);
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ALLOC;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        cfg_writes    = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero and odd sizes, oversize request, every free error.
        send_request(KIND_ALLOC, 0, 0);
        send_request(KIND_ALLOC, 1, 67108863);
        send_request(KIND_ALLOC, 64, 0);
        send_request(KIND_ALLOC, 65, 0);
        send_request(KIND_ALLOC, 67108864, 0);          // too big: exhausted
        send_request(KIND_FREE, 0, 0);                  // below header: outside
        send_request(KIND_FREE, 0, 63);
        send_request(KIND_FREE, 67108864, 67108863);    // inside, not a start
        send_request(KIND_FREE, 0, 64);                 // first block
        send_request(KIND_FREE, 0, 64);                 // double free
        send_request(KIND_FREE, 0, 192);                // second block, merges back
        send_request(KIND_FREE, 0, 192);                // merged-away start
        send_request(KIND_FREE, 0, 320);
        send_request(KIND_ALLOC, 67108864 - 1024, 0);   // big, splits off a small tail
        send_request(KIND_ALLOC, 67108864 - 128, 0);
        send_free(REL_LIVE);
        send_request(KIND_FREE, 0, 67108863);
        // Fill the table: many small allocations force the no-split path.
        run_random(300, 85);

        write_pool_length(0);                           // no pool
        send_request(KIND_ALLOC, 64, 0);
        send_request(KIND_FREE, 0, 64);
        run_random(8, 50);

        write_pool_length(127);                         // one short of the minimum
        run_random(10, 50);

        write_pool_length(128);                         // single granule pool
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_ALLOC, 1, 0);
        send_request(KIND_FREE, 0, 64);
        send_request(KIND_FREE, 0, 127);
        send_request(KIND_FREE, 0, 128);
        run_random(40, 50);

        write_pool_length(27'h7FF_FFFF);                // clamps to the address space
        run_random(300, 55);

        write_pool_length(16384);                       // small pool: frequent exhaustion
        quiet = 1'b1;
        run_random(150, 55);
        quiet = 1'b0;
        run_random(150, 55);

        write_pool_length(POOL_MAX);
        hold_req = 1'b1;
        run_random(400, 60);

        s_axis_tvalid = 1'b0;
        while (pool_sb.pending.size() != 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);

        $display("Covered %0d results over %0d pool settings: ok %0d, no pool %0d, %s %0d",
                 pool_sb.results_seen, cfg_writes + 1,
                 pool_sb.status_seen[ffa_pkg::ST_OK],
                 pool_sb.status_seen[ffa_pkg::ST_NO_POOL], "exhausted",
                 pool_sb.status_seen[ffa_pkg::ST_EXHAUSTED]);
        $display("Free errors: outside %0d, not a start %0d, double %0d; mismatches %0d",
                 pool_sb.status_seen[ffa_pkg::ST_OUTSIDE],
                 pool_sb.status_seen[ffa_pkg::ST_NOT_START],
                 pool_sb.status_seen[ffa_pkg::ST_DOUBLE], pool_sb.errors);
        if (pool_sb.errors == 0 && pool_sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_ram.sv
hdl/ffa_ctrl.sv
hdl/ffa_dp.sv
hdl/first_fit_dma_pool_allocator.sv
dv/tb.sv
